[hw/rtl/mrrc_pkg.sv]
// Shared types, constants and the CRC-16 byte update for the Modbus
// read-response checker. No dependencies; every other file imports this.
package mrrc_pkg;

  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam int          POS_W         = 4;
  localparam logic [3:0]  FRAME_BYTES   = 4'd9;
  localparam logic [3:0]  CRC_BYTES_END = 4'd7;
  localparam logic [3:0]  POS_WORD1_HI  = 4'd3;
  localparam logic [3:0]  POS_WORD1_LO  = 4'd4;
  localparam logic [3:0]  POS_WORD2_HI  = 4'd5;
  localparam logic [3:0]  POS_WORD2_LO  = 4'd6;
  localparam logic [3:0]  POS_LAST      = 4'd8;

  // One received byte with its frame start flag
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } item_t;

  // One checked frame
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [15:0] computed_crc;
  } result_t;

  // Frame tracker status toward the top level
  typedef struct packed {
    logic             take;
    logic [POS_W-1:0] pos;
  } frame_stat_t;

  // Reflected CRC-16 update over one byte, eight shift steps unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

[hw/rtl/mrrc_in_reg.sv]
// Input register of the Modbus read-response checker: holds one byte
// transfer until the frame tracker takes it. Depends on mrrc_pkg.
module mrrc_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_stall,
  input  mrrc_pkg::item_t in_item,
  output logic          item_valid,
  output mrrc_pkg::item_t item
);
  import mrrc_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // Advance whenever the tracker is not stalling the input
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on each open input slot
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

[hw/rtl/mrrc_frame.sv]
// Frame tracker: byte position, running CRC and register words, and the
// frame result built on the ninth byte. Depends on mrrc_pkg.
module mrrc_frame (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  mrrc_pkg::item_t      item,
  input  logic                 out_free,
  output mrrc_pkg::frame_stat_t stat,
  output logic                 res_valid,
  output mrrc_pkg::result_t    res
);
  import mrrc_pkg::*;

  logic [POS_W-1:0] pos_r,  pos_nxt;
  logic [15:0]      crc_r,  crc_nxt;
  logic [15:0]      w1_r,   w1_nxt;
  logic [15:0]      w2_r,   w2_nxt;
  logic [7:0]       low_r,  low_nxt;

  logic [POS_W-1:0] pos_eff;
  logic [15:0]      crc_eff, w1_eff, w2_eff;
  logic [7:0]       low_eff;
  logic             active;
  logic             last;
  logic             take;

  // A start flag restarts the frame at position zero, other state at reset values
  assign pos_eff = item.frame_start ? '0       : pos_r;
  assign crc_eff = item.frame_start ? CRC_INIT : crc_r;
  assign w1_eff  = item.frame_start ? 16'h0000 : w1_r;
  assign w2_eff  = item.frame_start ? 16'h0000 : w2_r;
  assign low_eff = item.frame_start ? 8'h00    : low_r;

  assign active = (pos_eff < FRAME_BYTES);
  assign last   = active && (pos_eff == POS_LAST);

  // Hold the byte only when its result cannot enter the output register
  assign take = item_valid && (!last || out_free);

  // Next frame state
  always_comb begin
    pos_nxt = pos_r;
    crc_nxt = crc_r;
    w1_nxt  = w1_r;
    w2_nxt  = w2_r;
    low_nxt = low_r;
    if (take) begin
      pos_nxt = pos_eff;
      crc_nxt = crc_eff;
      w1_nxt  = w1_eff;
      w2_nxt  = w2_eff;
      low_nxt = low_eff;
      if (active) begin
        pos_nxt = pos_eff + 4'd1;
        if (pos_eff < CRC_BYTES_END) begin
          crc_nxt = crc_byte(crc_eff, item.rx_byte);
        end
        if (pos_eff == POS_WORD1_HI || pos_eff == POS_WORD1_LO) begin
          w1_nxt = {w1_eff[7:0], item.rx_byte};
        end
        if (pos_eff == POS_WORD2_HI || pos_eff == POS_WORD2_LO) begin
          w2_nxt = {w2_eff[7:0], item.rx_byte};
        end
        if (pos_eff == CRC_BYTES_END) begin
          low_nxt = item.rx_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= FRAME_BYTES;
      crc_r <= CRC_INIT;
      w1_r  <= 16'h0000;
      w2_r  <= 16'h0000;
      low_r <= 8'h00;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      w1_r  <= w1_nxt;
      w2_r  <= w2_nxt;
      low_r <= low_nxt;
    end
  end

  // Build the frame result on the last byte
  assign res_valid        = take && last;
  assign res.crc_ok       = (crc_eff == {item.rx_byte, low_eff});
  assign res.first_word   = w1_eff;
  assign res.second_word  = w2_eff;
  assign res.computed_crc = crc_eff;

  assign stat.take = take;
  assign stat.pos  = pos_r;

endmodule

[hw/rtl/mrrc_out_reg.sv]
// Output register of the Modbus read-response checker: holds one result
// until the consumer takes the transfer. Depends on mrrc_pkg.
module mrrc_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  input  mrrc_pkg::result_t res,
  input  logic              out_stall,
  output logic              out_free,
  output logic              out_valid,
  output mrrc_pkg::result_t out_res
);
  import mrrc_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign out_free = !valid_r || !out_stall;

  // Load a new result, otherwise drop the one taken
  assign valid_nxt = res_valid ? 1'b1 : (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

[hw/rtl/modbus_read_response_checker.sv]
// Modbus RTU read-response checker: one received byte per transfer, one
// result per 9-byte frame. Each byte passes an input register, the frame
// tracker (position, CRC-16 0xA001 reflected, register words) and, on the
// ninth byte, an output register. Throughput is one byte per clock while
// the input is not stalled; the unrolled eight-step CRC update between
// the input register and the tracker state sets the critical path. The
// ninth byte's result enters the output register when the tracker takes
// that byte. A byte with in_frame_start begins a new frame and drops any
// partial one; bytes past the ninth are ignored until the next start.
// Input stalls only while a finished result waits behind a stalled
// output. Depends on mrrc_pkg, mrrc_in_reg, mrrc_frame and mrrc_out_reg.
module modbus_read_response_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_crc_ok,
  output logic [15:0] out_first_word,
  output logic [15:0] out_second_word,
  output logic [15:0] out_computed_crc
);
  import mrrc_pkg::*;

  item_t       in_item;
  item_t       item;
  logic        item_valid;
  logic        out_free;
  frame_stat_t stat;
  logic        res_valid;
  result_t     res;
  result_t     out_res;

  assign in_item.rx_byte     = in_rx_byte;
  assign in_item.frame_start = in_frame_start;

  // Stall input while the held byte cannot move on
  assign in_stall = item_valid && !stat.take;

  mrrc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item)
  );

  mrrc_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .stat       (stat),
    .res_valid  (res_valid),
    .res        (res)
  );

  mrrc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_crc_ok       = out_res.crc_ok;
  assign out_first_word   = out_res.first_word;
  assign out_second_word  = out_res.second_word;
  assign out_computed_crc = out_res.computed_crc;

`ifndef NO_ASSERTIONS
  // Byte position never passes the idle value
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pos <= FRAME_BYTES)
    else $error("byte position out of range");

  // A new result never overwrites one still held by a stalled output
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!out_valid || !out_stall))
    else $error("result overwrote held output");

  // A result is only produced from the ninth byte of a frame
  a_res_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (stat.pos == FRAME_BYTES) && out_valid)
    else $error("result without frame end");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");
`endif

endmodule
